// File: hw/rtl/bellman_ford_shortest_paths_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the shortest-path block
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH

// Same-cycle implication
`define BFSP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BFSP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bfsp_pkg.sv
// ---------------------------------------------------------------------------
// bfsp_pkg
// Shared types and fixed constants of the shortest-path block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfsp_pkg;

  // Fixed field widths
  localparam int VTX_W      = 7;
  localparam int WEIGHT_IN_W = 16;
  localparam int DIST_OUT_W = 22;

  // Saturation bounds of the reported distance
  localparam logic [DIST_OUT_W-1:0] DIST_OUT_MAX = {1'b0, {(DIST_OUT_W-1){1'b1}}};
  localparam logic [DIST_OUT_W-1:0] DIST_OUT_MIN = {1'b1, {(DIST_OUT_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_VERTEX = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FETCH,
    ST_DECODE,
    ST_ADD,
    ST_CMP,
    ST_OUT_RD,
    ST_OUT_EMIT
  } state_e;

endpackage

// File: hw/rtl/bfsp_ram.sv
// ---------------------------------------------------------------------------
// bfsp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/bellman_ford_shortest_paths.sv
// ---------------------------------------------------------------------------
// bellman_ford_shortest_paths
// Loads a directed weighted edge list, then runs single-source Bellman-Ford.
// ---------------------------------------------------------------------------
// Edges load at one item per cycle while busy_o is low. The item with
// last_edge set starts the run and busy_o stays high until the final result.
// The run takes a setup step, then one pass per active vertex over the
// stored edges: a skipped edge (vertex out of range or tail unreached) is
// fetched and decoded, a relaxed one also added and compared, as one
// edge-memory read, one distance-memory read, one shared wide adder and one
// comparator are used in turn. Output reads, then emits, each distance,
// or one result at once when a negative cycle shows up in the final pass.
// Each result is shown for exactly one cycle with result_valid_o high and
// cannot be held off. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bellman_ford_shortest_paths import bfsp_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Edge items
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [VTX_W-1:0]             from_vertex_i,
  input  logic [VTX_W-1:0]             to_vertex_i,
  input  logic signed [WEIGHT_IN_W-1:0] edge_weight_i,
  input  logic                         last_edge_i,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [VTX_W-1:0]             cfg_data_i,
  // Results
  output logic                         result_valid_o,
  output logic [VTX_W-1:0]             vertex_o,
  output logic signed [DIST_OUT_W-1:0] distance_o,
  output logic                         reachable_o,
  output logic                         negative_cycle_o,
  output logic                         edge_overflow_o,
  output logic                         last_result_o
);

  localparam int VIDX_W    = $clog2(MAX_VERTICES);
  localparam int EADDR_W   = $clog2(MAX_EDGES);
  localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W    = 2 * VTX_W + WEIGHT_BITS;
  localparam int RAW_W     = (WEIGHT_BITS > WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
  localparam int DIST_SPAN = WEIGHT_BITS + $clog2(MAX_VERTICES * MAX_EDGES) + 1;
  localparam int DIST_W    = (DIST_SPAN > DIST_OUT_W + 1) ? DIST_SPAN : DIST_OUT_W + 1;

  state_e state_q, state_d;

  logic [VTX_W-1:0]        vertex_count_q, source_vertex_q;
  logic [ECNT_W-1:0]       edge_count_q;
  logic                    overflow_q;
  logic [MAX_VERTICES-1:0] valid_q;
  logic [ECNT_W-1:0]       idx_q;
  logic [VTX_W-1:0]        pass_q;
  logic [VTX_W-1:0]        out_vtx_q;
  logic signed [DIST_W-1:0] cand_q;

  logic                         res_valid_q;
  logic [VTX_W-1:0]             vertex_q;
  logic [DIST_OUT_W-1:0]        distance_q;
  logic                         reachable_q;
  logic                         neg_q;
  logic                         ovf_q;
  logic                         last_q;

  logic [VTX_W-1:0]       v_act;
  logic                   src_ok, in_ok, accept;
  logic [RAW_W-1:0]       raw_wt;
  logic [EDGE_W-1:0]      e_wdata, e_rdata;
  logic [VTX_W-1:0]       e_from, e_to;
  logic [WEIGHT_BITS-1:0] e_wt;
  logic                   e_ok;
  logic [VIDX_W-1:0]      from_idx, to_idx, out_idx, src_idx;
  logic [VIDX_W-1:0]      dist_raddr_a, dist_waddr;
  logic signed [DIST_W-1:0] dist_a, dist_b, w_ext, dist_wdata;
  logic                   dist_we;
  logic                   improve, last_pass, edge_last;
  logic                   step, emit, neg_found;
  logic                   out_in_rng;
  logic [DIST_OUT_W-1:0]  out_dist;

  // Clamp the vertex count to 1..MAX_VERTICES
  always_comb begin
    if (vertex_count_q == '0) begin
      v_act = VTX_W'(1);
    end else if (vertex_count_q > VTX_W'(MAX_VERTICES)) begin
      v_act = VTX_W'(MAX_VERTICES);
    end else begin
      v_act = vertex_count_q;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy_o;
  assign accept      = start_i && !busy_o;

  // Load-side edge check and packing
  assign in_ok = (from_vertex_i != '0) && (from_vertex_i <= v_act) &&
                 (to_vertex_i != '0) && (to_vertex_i <= v_act) &&
                 (edge_count_q < ECNT_W'(MAX_EDGES));
  assign raw_wt  = RAW_W'($unsigned(edge_weight_i));
  assign e_wdata = {from_vertex_i, to_vertex_i, raw_wt[WEIGHT_BITS-1:0]};

  // Unpack the stored edge
  assign e_from = e_rdata[EDGE_W-1 -: VTX_W];
  assign e_to   = e_rdata[WEIGHT_BITS +: VTX_W];
  assign e_wt   = e_rdata[WEIGHT_BITS-1:0];
  assign w_ext  = DIST_W'($signed(e_wt));
  assign e_ok   = (e_from != '0) && (e_from <= v_act) && (e_to != '0) && (e_to <= v_act);

  assign from_idx = VIDX_W'(e_from - VTX_W'(1));
  assign to_idx   = VIDX_W'(e_to - VTX_W'(1));
  assign out_idx  = VIDX_W'(out_vtx_q - VTX_W'(1));
  assign src_idx  = VIDX_W'(source_vertex_q - VTX_W'(1));
  assign src_ok   = (source_vertex_q != '0) && (source_vertex_q <= v_act);

  assign improve   = !valid_q[to_idx] || (cand_q < dist_b);
  assign last_pass = (pass_q == v_act - VTX_W'(1));
  assign edge_last = ((idx_q + ECNT_W'(1)) == edge_count_q);

  assign dist_raddr_a = (state_q == ST_OUT_RD || state_q == ST_OUT_EMIT) ? out_idx : from_idx;

  // Sequencer: next state and per-cycle controls
  always_comb begin
    state_d    = state_q;
    step       = 1'b0;
    emit       = 1'b0;
    neg_found  = 1'b0;
    dist_we    = 1'b0;
    dist_waddr = to_idx;
    dist_wdata = cand_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && last_edge_i) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        dist_we    = src_ok;
        dist_waddr = src_idx;
        dist_wdata = '0;
        state_d    = (edge_count_q == '0) ? ST_OUT_RD : ST_FETCH;
      end
      ST_FETCH: begin
        state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (e_ok && valid_q[from_idx]) begin
          state_d = ST_ADD;
        end else begin
          step = 1'b1;
        end
      end
      ST_ADD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (improve) begin
          dist_we = 1'b1;
          if (last_pass) begin
            neg_found = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            step = 1'b1;
          end
        end else begin
          step = 1'b1;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        emit    = 1'b1;
        state_d = (out_vtx_q == v_act) ? ST_IDLE : ST_OUT_RD;
      end
    endcase
    // Advance to the next edge or the next pass
    if (step) begin
      if (edge_last && (pass_q + VTX_W'(1) == v_act)) begin
        state_d = ST_OUT_RD;
      end else begin
        state_d = ST_FETCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q  <= VTX_W'(1);
      source_vertex_q <= VTX_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_VERTEX_COUNT:  vertex_count_q  <= cfg_data_i;
        CFG_SOURCE_VERTEX: source_vertex_q <= cfg_data_i;
      endcase
    end
  end

  // Edge count and overflow: count or drop on load, clear at run end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q <= '0;
      overflow_q   <= 1'b0;
    end else if (busy_o && state_d == ST_IDLE) begin
      edge_count_q <= '0;
      overflow_q   <= 1'b0;
    end else if (accept) begin
      if (in_ok) begin
        edge_count_q <= edge_count_q + ECNT_W'(1);
      end else begin
        overflow_q <= 1'b1;
      end
    end
  end

  // Reached flags: seed the source, mark relaxed heads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (state_q == ST_INIT) begin
      valid_q <= src_ok ? (MAX_VERTICES'(1) << src_idx) : '0;
    end else if (state_q == ST_CMP && dist_we) begin
      valid_q[to_idx] <= 1'b1;
    end
  end

  // Edge and pass counters, output vertex counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      pass_q    <= '0;
      out_vtx_q <= VTX_W'(1);
    end else if (state_q == ST_INIT) begin
      idx_q     <= '0;
      pass_q    <= '0;
      out_vtx_q <= VTX_W'(1);
    end else if (step) begin
      if (edge_last) begin
        idx_q  <= '0;
        pass_q <= pass_q + VTX_W'(1);
      end else begin
        idx_q <= idx_q + ECNT_W'(1);
      end
    end else if (emit) begin
      out_vtx_q <= out_vtx_q + VTX_W'(1);
    end
  end

  // Shared adder: candidate distance through the tail
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ADD) begin
      cand_q <= dist_a + w_ext;
    end
  end

  // Saturate the reported distance to the output range
  assign out_in_rng = (&dist_a[DIST_W-1:DIST_OUT_W-1]) || !(|dist_a[DIST_W-1:DIST_OUT_W-1]);
  always_comb begin
    if (out_in_rng) begin
      out_dist = dist_a[DIST_OUT_W-1:0];
    end else begin
      out_dist = dist_a[DIST_W-1] ? DIST_OUT_MIN : DIST_OUT_MAX;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit || neg_found;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (neg_found) begin
      vertex_q    <= '0;
      distance_q  <= '0;
      reachable_q <= 1'b0;
      neg_q       <= 1'b1;
      ovf_q       <= overflow_q;
      last_q      <= 1'b1;
    end else if (emit) begin
      vertex_q    <= out_vtx_q;
      distance_q  <= valid_q[out_idx] ? out_dist : '0;
      reachable_q <= valid_q[out_idx];
      neg_q       <= 1'b0;
      ovf_q       <= overflow_q;
      last_q      <= (out_vtx_q == v_act);
    end
  end

  assign result_valid_o   = res_valid_q;
  assign vertex_o         = vertex_q;
  assign distance_o       = distance_q;
  assign reachable_o      = reachable_q;
  assign negative_cycle_o = neg_q;
  assign edge_overflow_o  = ovf_q;
  assign last_result_o    = last_q;

  // Edge list memory
  bfsp_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (accept && in_ok),
    .waddr_i (edge_count_q[EADDR_W-1:0]),
    .wdata_i (e_wdata),
    .raddr_i (idx_q[EADDR_W-1:0]),
    .rdata_o (e_rdata)
  );

  // Distance memory, tail-side copy (also read for output)
  bfsp_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram_a (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (dist_raddr_a),
    .rdata_o (dist_a)
  );

  // Distance memory, head-side copy
  bfsp_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram_b (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (to_idx),
    .rdata_o (dist_b)
  );

  `include "bellman_ford_shortest_paths_assert.svh"

  `BFSP_ASSERT_IMPL(a_neg_is_last, res_valid_q && neg_q, last_q, "negative cycle result not last")
  `BFSP_ASSERT_NEXT(a_run_starts, start_i && !busy_o && last_edge_i, busy_o, "run did not start")
  `BFSP_ASSERT_IMPL(a_busy_mid_run, res_valid_q && !last_q, busy_o, "idle before final result")
  `BFSP_ASSERT_IMPL(a_idle_at_last, res_valid_q && last_q, !busy_o, "busy after final result")

endmodule

// File: sim/tb_bellman_ford_shortest_paths.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bellman_ford_shortest_paths
// Loads batches of weighted edges into the shortest-path block and checks
// every reported distance, reachability flag, cycle flag and overflow flag
// against a predictor that relaxes the same edge list in the same order.
// ---------------------------------------------------------------------------
module tb_bellman_ford_shortest_paths;
  import bfsp_pkg::*;

  localparam int VMAX         = 64;
  localparam int EDGE_CAP     = 1024;
  localparam int WBITS        = 16;
  localparam int RANDOM_ITEMS = 276;
  localparam int QUIET_TAIL   = 80;
  localparam int SETTLE       = 8;
  localparam int DRAIN        = 16;
  // Cycle limit that ends a hung test.
  localparam int LIMIT        = 2_000_000;
  localparam longint DIST_HI  = (longint'(1) <<< (DIST_OUT_W - 1)) - 1;
  localparam longint DIST_LO  = -DIST_HI - 1;

  typedef struct packed {
    logic [VTX_W-1:0]              tail;
    logic [VTX_W-1:0]              head;
    logic signed [WEIGHT_IN_W-1:0] cost;
  } arc_t;

  typedef struct packed {
    logic [VTX_W-1:0]             vertex;
    logic signed [DIST_OUT_W-1:0] distance;
    logic                         reachable;
    logic                         negative_cycle;
    logic                         edge_overflow;
    logic                         last_result;
  } report_t;

  // Edge list, register copies and the queue of distance reports still due
  class path_ledger;
    logic [VTX_W-1:0] vertex_count;
    logic [VTX_W-1:0] source_vertex;
    arc_t             arcs[$];
    bit               dropped;
    report_t          due[$];
    int               errors;

    function new();
      vertex_count  = VTX_W'(1);
      source_vertex = VTX_W'(1);
      dropped       = 1'b0;
      errors        = 0;
    endfunction

    function void set_reg(logic idx, logic [VTX_W-1:0] val);
      if (idx == CFG_VERTEX_COUNT) vertex_count = val;
      else source_vertex = val;
    endfunction

    function int active_count();
      if (vertex_count == 0) return 1;
      if (vertex_count > VMAX) return VMAX;
      return int'(vertex_count);
    endfunction

    // Store or drop one edge; on the last edge relax the list and queue reports
    function void load_edge(arc_t e, bit last);
      int      v;
      int      src;
      int      a;
      int      b;
      bit      cycle;
      longint  best [0:VMAX];
      bit      seen [0:VMAX];
      longint  cand;
      report_t r;
      v = active_count();
      if (e.tail >= 1 && e.tail <= v && e.head >= 1 && e.head <= v &&
          arcs.size() < EDGE_CAP) begin
        arcs.push_back(e);
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;

      for (int k = 0; k <= VMAX; k++) begin
        seen[k] = 1'b0;
        best[k] = 0;
      end
      src = int'(source_vertex);
      if (src >= 1 && src <= v) seen[src] = 1'b1;

      // V passes in arrival order; any gain in the final pass is a cycle
      cycle = 1'b0;
      for (int p = 0; p < v && !cycle; p++) begin
        for (int i = 0; i < arcs.size(); i++) begin
          a = int'(arcs[i].tail);
          b = int'(arcs[i].head);
          if (a < 1 || a > v || b < 1 || b > v || !seen[a]) continue;
          cand = best[a] + longint'(arcs[i].cost);
          if (!seen[b] || cand < best[b]) begin
            best[b] = cand;
            seen[b] = 1'b1;
            if (p == v - 1) begin
              cycle = 1'b1;
              break;
            end
          end
        end
      end

      if (cycle) begin
        r = '0;
        r.negative_cycle = 1'b1;
        r.edge_overflow  = dropped;
        r.last_result    = 1'b1;
        due.push_back(r);
      end else begin
        for (int k = 1; k <= v; k++) begin
          cand = seen[k] ? best[k] : 0;
          if (cand > DIST_HI) cand = DIST_HI;
          if (cand < DIST_LO) cand = DIST_LO;
          r = '0;
          r.vertex        = VTX_W'(k);
          r.distance      = DIST_OUT_W'(cand);
          r.reachable     = seen[k];
          r.edge_overflow = dropped;
          r.last_result   = (k == v);
          due.push_back(r);
        end
      end
      arcs.delete();
      dropped = 1'b0;
    endfunction

    // Compare one shown result with the oldest report due
    function void check_report(logic [VTX_W-1:0] vtx, logic signed [DIST_OUT_W-1:0] dst,
                               logic reach, logic neg, logic ovf, logic fin);
      report_t want;
      if (due.size() == 0) begin
        $error("result with no report due: vertex %0d distance %0d", vtx, dst);
        errors++;
        return;
      end
      want = due.pop_front();
      if (vtx !== want.vertex) begin
        $error("vertex: expected %0d, got %0d", want.vertex, vtx);
        errors++;
      end
      if (dst !== want.distance) begin
        $error("distance: expected %0d, got %0d", want.distance, dst);
        errors++;
      end
      if (reach !== want.reachable) begin
        $error("reachable: expected %0d, got %0d", want.reachable, reach);
        errors++;
      end
      if (neg !== want.negative_cycle) begin
        $error("negative_cycle: expected %0d, got %0d", want.negative_cycle, neg);
        errors++;
      end
      if (ovf !== want.edge_overflow) begin
        $error("edge_overflow: expected %0d, got %0d", want.edge_overflow, ovf);
        errors++;
      end
      if (fin !== want.last_result) begin
        $error("last_result: expected %0d, got %0d", want.last_result, fin);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          start_i       = 1'b0;
  logic                          busy_o;
  logic [VTX_W-1:0]              from_vertex_i = '0;
  logic [VTX_W-1:0]              to_vertex_i   = '0;
  logic signed [WEIGHT_IN_W-1:0] edge_weight_i = '0;
  logic                          last_edge_i   = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic                          cfg_index_i   = CFG_VERTEX_COUNT;
  logic [VTX_W-1:0]              cfg_data_i    = '0;
  logic                          result_valid_o;
  logic [VTX_W-1:0]              vertex_o;
  logic signed [DIST_OUT_W-1:0]  distance_o;
  logic                          reachable_o;
  logic                          negative_cycle_o;
  logic                          edge_overflow_o;
  logic                          last_result_o;

  path_ledger ledger;
  int         items_sent = 0;
  int         cycles     = 0;

  bellman_ford_shortest_paths #(
    .MAX_VERTICES(VMAX),
    .MAX_EDGES   (EDGE_CAP),
    .WEIGHT_BITS (WBITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .from_vertex_i   (from_vertex_i),
    .to_vertex_i     (to_vertex_i),
    .edge_weight_i   (edge_weight_i),
    .last_edge_i     (last_edge_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .vertex_o        (vertex_o),
    .distance_o      (distance_o),
    .reachable_o     (reachable_o),
    .negative_cycle_o(negative_cycle_o),
    .edge_overflow_o (edge_overflow_o),
    .last_result_o   (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Check each shown result at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      ledger.check_report(vertex_o, distance_o, reachable_o, negative_cycle_o,
                          edge_overflow_o, last_result_o);
    end
  end

  // Offer one edge item and hold it until the block takes it
  task automatic send_edge(input int a, input int b, input int w, input int last);
    arc_t e;
    start_i       <= 1'b1;
    from_vertex_i <= VTX_W'(a);
    to_vertex_i   <= VTX_W'(b);
    edge_weight_i <= WEIGHT_IN_W'(w);
    last_edge_i   <= (last != 0);
    do @(posedge clk_i); while (busy_o);
    e.tail = VTX_W'(a);
    e.head = VTX_W'(b);
    e.cost = WEIGHT_IN_W'(w);
    ledger.load_edge(e, last != 0);
    items_sent++;
  endtask

  // Drop start and idle for a number of cycles
  task automatic hold_off(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Wait for every due report, then let the block settle
  task automatic drain_runs();
    start_i <= 1'b0;
    while (ledger.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input int val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= VTX_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ledger.set_reg(idx, VTX_W'(val));
  endtask

  task automatic configure(input int vc, input int src);
    drain_runs();
    write_cfg(CFG_VERTEX_COUNT, vc);
    write_cfg(CFG_SOURCE_VERTEX, src);
  endtask

  // Reverse-ordered path over all vertices: one vertex settles per pass
  task automatic chain_batch(input int w);
    configure(VMAX, 1);
    for (int k = VMAX - 1; k >= 1; k--) send_edge(k, k + 1, w, int'(k == 1));
  endtask

  // One batch of mostly valid edges with random weights and sizes
  task automatic random_batch(input bit idle_ok);
    int v;
    int n;
    int sel;
    int shrink_at;
    int vc;
    int src;
    int a;
    int b;
    int w;
    sel = $urandom_range(19, 0);
    if (sel == 0) vc = 0;
    else if (sel == 1) vc = $urandom_range(127, VMAX + 1);
    else if (sel <= 3) vc = $urandom_range(VMAX, 11);
    else vc = $urandom_range(10, 1);
    v = (vc == 0) ? 1 : (vc > VMAX) ? VMAX : vc;
    sel = $urandom_range(9, 0);
    if (sel == 0) src = 0;
    else if (sel == 1) src = $urandom_range(127, v + 1);
    else src = $urandom_range(v, 1);
    configure(vc, src);

    n = (v > 16) ? $urandom_range(24, 1) : $urandom_range(12, 1);
    shrink_at = ($urandom_range(9, 0) == 0) ? $urandom_range(n - 1, 0) : -1;
    for (int k = 0; k < n; k++) begin
      // shrink the vertex count with edges already stored
      if (k == shrink_at) begin
        drain_runs();
        v = $urandom_range(v, 1);
        write_cfg(CFG_VERTEX_COUNT, v);
      end
      if (idle_ok && $urandom_range(3, 0) == 0) hold_off($urandom_range(16, 1));
      if ($urandom_range(9, 0) == 0) begin
        a = $urandom_range(127, 0);
        b = $urandom_range(127, 0);
      end else begin
        a = $urandom_range(v, 1);
        b = $urandom_range(v, 1);
      end
      sel = $urandom_range(9, 0);
      if (sel <= 5) w = $urandom_range(200, 0);
      else if (sel <= 7) w = -int'($urandom_range(50, 1));
      else if (sel == 8) w = int'($urandom_range(65535, 0)) - 32768;
      else w = $urandom_range(1, 0) ? 32767 : -32768;
      send_edge(a, b, w, int'(k == n - 1));
    end
  endtask

  initial begin
    int base;
    ledger = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one vertex, source 1
    send_edge(1, 1, 0, 1);
    // Zero count acts as one vertex; a negative self loop is a cycle
    configure(0, 1);
    send_edge(1, 1, -1, 1);
    // Count saturates at the maximum; extreme weights and dropped edges
    configure(127, VMAX);
    send_edge(VMAX, 1, 32767, 0);
    send_edge(1, 2, -32768, 0);
    send_edge(3, 5, 7, 0);
    send_edge(0, 1, 1, 0);
    send_edge(VMAX + 1, 1, 1, 0);
    send_edge(2, 127, 1, 1);
    // Source zero: nothing reached, so the loop below is not a cycle
    configure(4, 0);
    send_edge(1, 2, 3, 0);
    send_edge(2, 1, -5, 1);
    // Source above the count
    configure(4, 5);
    send_edge(4, 3, 1, 1);
    // Reachable two-vertex negative loop
    configure(3, 1);
    send_edge(1, 2, 4, 0);
    send_edge(2, 3, -2, 0);
    send_edge(3, 2, -3, 1);
    // Edges stored at eight vertices, run with four
    configure(8, 1);
    send_edge(1, 6, 2, 0);
    send_edge(6, 2, 2, 0);
    send_edge(1, 4, 9, 0);
    drain_runs();
    write_cfg(CFG_VERTEX_COUNT, 4);
    send_edge(4, 3, -3, 1);

    // Longest paths at both weight extremes
    chain_batch(-32768);
    chain_batch(32767);

    // Random batches; the tail runs with no idling
    base = items_sent;
    while (items_sent < base + RANDOM_ITEMS) begin
      random_batch(items_sent < base + RANDOM_ITEMS - QUIET_TAIL);
    end

    drain_runs();
    repeat (DRAIN) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // End a hung run
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
